// ----- src/conrx_pkg.sv -----
// ----------------------------------------------------------------------------
// conrx_pkg
// Shared types, constants and helpers for the console receive byte ring.
// ----------------------------------------------------------------------------
package conrx_pkg;

	localparam int RING_DEPTH = 4096;
	localparam int IDX_W      = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;

	typedef logic [IDX_W-1:0] idx_t;

	// request codes
	localparam logic [1:0] REQ_PUT = 2'd0;
	localparam logic [1:0] REQ_GET = 2'd1;
	localparam logic [1:0] REQ_BRK = 2'd2;
	localparam logic [1:0] REQ_NOP = 2'd3;

	localparam logic [7:0] BREAK_BYTE = 8'h03;

	// control sequence ^R ^E ^S ^E ^T
	localparam int SEQ_LEN = 5;
	typedef logic [2:0] seq_pos_t;
	localparam seq_pos_t SEQ_LAST = seq_pos_t'(SEQ_LEN - 1);

	typedef struct packed {
		logic [1:0] req_type;
		logic [7:0] char_in;
	} req_t;

	typedef struct packed {
		logic [7:0] char_out;
		logic       char_valid;
		logic       break_found;
		logic       dropped;
		logic       overflow_mark;
		logic       reset_request;
	} rsp_t;

	function automatic logic [7:0] seq_byte(input seq_pos_t pos);
		logic [7:0] b;
		case (pos)
			3'd0:    b = 8'h12;
			3'd1:    b = 8'h05;
			3'd2:    b = 8'h13;
			3'd3:    b = 8'h05;
			3'd4:    b = 8'h14;
			default: b = 8'h00;
		endcase
		return b;
	endfunction

	// circular increment, works for any depth
	function automatic idx_t ring_next(input idx_t pos);
		idx_t n;
		if (pos == idx_t'(RING_DEPTH - 1)) begin
			n = '0;
		end else begin
			n = pos + idx_t'(1);
		end
		return n;
	endfunction

endpackage

// ----- src/console_rx_fifo_with_break_and_magic_core.sv -----
// ----------------------------------------------------------------------------
// console_rx_fifo_with_break_and_magic_core
// Console receive byte ring with overflow marking, break scan and a
// control-sequence reset request.
// ----------------------------------------------------------------------------
//
//  channel | signals                       | beat contents
//  --------+-------------------------------+-----------------------------------
//  request | req_valid, req_ready, req     | req_type, char_in
//  result  | rsp_valid, rsp_ready, rsp     | char_out, char_valid, break_found,
//          |                               | dropped, overflow_mark, reset_request
//
// Put, no-op and requests on an empty ring load their result directly; a get
// of a stored byte first goes through the registered read of the ring memory;
// a break check walks the stored bytes, one memory read per cycle.
// Reset clears the indices, matcher and last-fail position; the ring memory
// itself is not cleared and needs no sweep.
// A waiting result does not block the next request as long as it is taken
// in the cycle the request is accepted; otherwise req_ready stays low.
//
module console_rx_fifo_with_break_and_magic_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	input  conrx_pkg::req_t   req,
	output logic              rsp_valid,
	input  logic              rsp_ready,
	output conrx_pkg::rsp_t   rsp
);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_GET  = 3'b010,
		ST_SCAN = 3'b100
	} state_t;

	state_t state_q, state_d;

	conrx_pkg::idx_t wr_idx_q, wr_idx_d;
	conrx_pkg::idx_t rd_idx_q, rd_idx_d;
	conrx_pkg::idx_t fail_idx_q, fail_idx_d;
	conrx_pkg::idx_t cur_q, cur_d;

	conrx_pkg::rsp_t rsp_q, rsp_d;
	logic            rsp_valid_q;
	logic            rsp_load;

	// ring memory, one write and one read port
	logic [7:0]      ring_mem [conrx_pkg::RING_DEPTH];
	logic [7:0]      rd_data_q;
	conrx_pkg::idx_t rd_addr;
	logic            rd_en;
	logic            wr_en;

	logic            acc;
	logic            put_step;
	logic            seq_done;
	logic            ring_empty;
	logic            ring_full;
	conrx_pkg::idx_t wr_next;
	conrx_pkg::idx_t cur_next;

	assign acc        = req_valid && req_ready;
	assign req_ready  = (state_q == ST_IDLE) && (!rsp_valid_q || rsp_ready);
	assign rsp_valid  = rsp_valid_q;
	assign rsp        = rsp_q;

	assign wr_next    = conrx_pkg::ring_next(wr_idx_q);
	assign cur_next   = conrx_pkg::ring_next(cur_q);
	assign ring_empty = (rd_idx_q == wr_idx_q);
	assign ring_full  = (wr_next == rd_idx_q);
	assign put_step   = acc && (req.req_type == conrx_pkg::REQ_PUT);

	conrx_seq_match u_seq (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (put_step),
		.ch      (req.char_in),
		.seq_done(seq_done)
	);

	// Next-state and result logic
	always_comb begin
		state_d    = state_q;
		wr_idx_d   = wr_idx_q;
		rd_idx_d   = rd_idx_q;
		fail_idx_d = fail_idx_q;
		cur_d      = cur_q;
		rsp_d      = '0;
		rsp_load   = 1'b0;
		wr_en      = 1'b0;
		rd_en      = 1'b0;
		rd_addr    = rd_idx_q;

		unique case (state_q)
			ST_IDLE: begin
				if (acc) begin
					unique case (req.req_type)
						conrx_pkg::REQ_PUT: begin
							rsp_load = 1'b1;
							if (seq_done) begin
								// sequence complete: byte swallowed, no full check
								rsp_d.reset_request = 1'b1;
							end else if (ring_full) begin
								rsp_d.dropped = 1'b1;
								// one mark per failing write position
								if (fail_idx_q != wr_next) begin
									fail_idx_d          = wr_next;
									rsp_d.overflow_mark = 1'b1;
								end
							end else begin
								wr_en    = 1'b1;
								wr_idx_d = wr_next;
							end
						end
						conrx_pkg::REQ_GET: begin
							if (ring_empty) begin
								rsp_load = 1'b1;
							end else begin
								rd_en    = 1'b1;
								rd_idx_d = conrx_pkg::ring_next(rd_idx_q);
								state_d  = ST_GET;
							end
						end
						conrx_pkg::REQ_BRK: begin
							if (ring_empty) begin
								rsp_load = 1'b1;
							end else begin
								rd_en   = 1'b1;
								cur_d   = rd_idx_q;
								state_d = ST_SCAN;
							end
						end
						conrx_pkg::REQ_NOP: begin
							rsp_load = 1'b1;
						end
						default: begin
							rsp_load = 1'b1;
						end
					endcase
				end
			end
			ST_GET: begin
				rsp_load         = 1'b1;
				rsp_d.char_out   = rd_data_q;
				rsp_d.char_valid = 1'b1;
				state_d          = ST_IDLE;
			end
			ST_SCAN: begin
				// rd_data_q holds the byte at cur_q
				if (rd_data_q == conrx_pkg::BREAK_BYTE) begin
					rd_idx_d          = cur_next;
					rsp_load          = 1'b1;
					rsp_d.break_found = 1'b1;
					state_d           = ST_IDLE;
				end else if (cur_next == wr_idx_q) begin
					rsp_load = 1'b1;
					state_d  = ST_IDLE;
				end else begin
					rd_en   = 1'b1;
					rd_addr = cur_next;
					cur_d   = cur_next;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			wr_idx_q    <= '0;
			rd_idx_q    <= '0;
			fail_idx_q  <= '0;
			cur_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q    <= state_d;
			wr_idx_q   <= wr_idx_d;
			rd_idx_q   <= rd_idx_d;
			fail_idx_q <= fail_idx_d;
			cur_q      <= cur_d;
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// result payload, no reset needed
	always_ff @(posedge clk) begin
		if (rsp_load) begin
			rsp_q <= rsp_d;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			ring_mem[wr_idx_q] <= req.char_in;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= ring_mem[rd_addr];
		end
	end

	// ------------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------------

	// while a get or scan is in flight the result register is free
	a_busy_no_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> !rsp_valid_q)
		else $error("result pending during get or scan");

	// a completed control sequence never stores its last byte
	a_seq_no_store: assert property (@(posedge clk) disable iff (!arst_n)
		(put_step && seq_done) |=> (wr_idx_q == $past(wr_idx_q)))
		else $error("write index moved on control sequence completion");

	// a get on a non-empty ring answers with a valid byte, via ST_GET and the result register
	a_get_answer: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && (req.req_type == conrx_pkg::REQ_GET) && !ring_empty)
		|=> ##1 (rsp_valid_q && rsp_q.char_valid))
		else $error("get did not return a byte");

	// indices stay inside the ring
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		(int'(wr_idx_q) < conrx_pkg::RING_DEPTH) && (int'(rd_idx_q) < conrx_pkg::RING_DEPTH))
		else $error("ring index out of range");

endmodule

// ----- src/conrx_seq_match.sv -----
// ----------------------------------------------------------------------------
// conrx_seq_match
// Tracks the five-byte control sequence over put beats.
// ----------------------------------------------------------------------------
module conrx_seq_match (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  logic [7:0] ch,
	output logic       seq_done
);

	conrx_pkg::seq_pos_t pos_q;
	logic                hit;

	assign hit      = (ch == conrx_pkg::seq_byte(pos_q));
	assign seq_done = hit && (pos_q == conrx_pkg::SEQ_LAST);

	// mismatch restarts at zero without retesting the first byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (step) begin
			if (hit && !seq_done) begin
				pos_q <= pos_q + 3'd1;
			end else begin
				pos_q <= '0;
			end
		end
	end

endmodule
